>>> src/spq_pkg.sv
// Shared types and constants for the sorted insertion priority queue.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int CODE_W    = 16;
	localparam int PRIO_W    = 8;
	localparam int STATUS_W  = 2;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DUMP   = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ENTRY  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// Control broadcast from the sequencer to every cell of the chain.
	typedef struct packed {
		logic   insert;
		logic   rotate;
		entry_t new_entry;
	} cell_ctrl_t;

endpackage

>>> src/spq_if.sv
// Handshake interfaces for the request and response channels.
`timescale 1ns / 1ps

interface spq_req_if;
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic [spq_pkg::CODE_W-1:0] item_code;
	logic [spq_pkg::PRIO_W-1:0] item_priority;

	modport source (output valid, output cmd, output item_code, output item_priority,
		input ready);
	modport sink (input valid, input cmd, input item_code, input item_priority,
		output ready);
endinterface

interface spq_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [spq_pkg::CODE_W-1:0]   out_code;
	logic [spq_pkg::PRIO_W-1:0]   out_priority;
	logic [spq_pkg::STATUS_W-1:0] status;
	logic                         last;

	modport source (output valid, output out_code, output out_priority, output status,
		output last, input ready);
	modport sink (input valid, input out_code, input out_priority, input status,
		input last, output ready);
endinterface

>>> src/spq_cell.sv
// One storage cell of the sorted chain: compares, shifts on insert, rotates on dump.
`timescale 1ns / 1ps

module spq_cell #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF,
	parameter int IDX   = 0,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic [CNT_W-1:0]    count,
	input  spq_pkg::entry_t     left_entry,
	input  logic                left_greater,
	input  spq_pkg::entry_t     right_entry,
	input  spq_pkg::entry_t     head_entry,
	output spq_pkg::entry_t     entry,
	output logic                greater
);
	import spq_pkg::*;

	entry_t entry_q;
	logic   occupied;
	logic   tail;

	assign occupied = CNT_W'(IDX) < count;
	assign tail     = count == CNT_W'(IDX + 1);

	// An empty cell sorts behind everything, so the new entry lands in the
	// first cell that is empty or holds a strictly larger priority.
	assign greater = !occupied || (entry_q.prio > ctrl.new_entry.prio);

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (left_greater) begin
				entry_q <= left_entry;
			end else if (greater) begin
				entry_q <= ctrl.new_entry;
			end
		end else if (ctrl.rotate && occupied) begin
			entry_q <= tail ? head_entry : right_entry;
		end
	end

	assign entry = entry_q;

endmodule

>>> src/sorted_insert_priority_queue_top.sv
// Insert latency: the status word is valid in the cycle after the request is accepted.
// Dump: acceptance enters the dump state, then the head cell is registered out one entry per
// cycle while the response side takes words; the request side is held off until all are out.
// Inserts sustain one per cycle while the response side keeps taking words.
// Reset empties the queue by clearing the entry count; cell contents need no clearing.
`timescale 1ns / 1ps

module sorted_insert_priority_queue_top #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	spq_req_if.sink  req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DUMP = 2'b10
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] remaining_q;

	logic                rsp_valid_q;
	entry_t              rsp_entry_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic                rsp_last_q;

	entry_t     cell_entry [DEPTH];
	logic       cell_greater [DEPTH];
	cell_ctrl_t ctrl;

	logic out_free;
	logic req_fire;
	logic full;
	logic dump_step;
	logic rsp_valid_d;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign req_fire  = req.valid && req.ready;
	assign full      = count_q == CNT_W'(DEPTH);
	assign dump_step = (state_q == S_DUMP) && out_free;

	// A dump of a non-empty queue gives no word on acceptance; the chain starts next cycle.
	assign rsp_valid_d = dump_step ||
		(req_fire && !((req.cmd == CMD_DUMP) && (count_q != '0))) ||
		(rsp_valid_q && !rsp.ready);

	assign ctrl.insert         = req_fire && (req.cmd == CMD_INSERT) && !full;
	assign ctrl.rotate         = dump_step;
	assign ctrl.new_entry.code = req.item_code;
	assign ctrl.new_entry.prio = req.item_priority;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_e;
		logic   left_g;
		entry_t right_e;

		if (i == 0) begin : g_first
			assign left_e = '0;
			assign left_g = 1'b0;
		end else begin : g_inner
			assign left_e = cell_entry[i-1];
			assign left_g = cell_greater[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign right_e = cell_entry[0];
		end else begin : g_mid
			assign right_e = cell_entry[i+1];
		end

		spq_cell #(
			.DEPTH(DEPTH),
			.IDX  (i),
			.CNT_W(CNT_W)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.count       (count_q),
			.left_entry  (left_e),
			.left_greater(left_g),
			.right_entry (right_e),
			.head_entry  (cell_entry[0]),
			.entry       (cell_entry[i]),
			.greater     (cell_greater[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			remaining_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= rsp_valid_d;
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (req.cmd == CMD_INSERT) begin
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
							end
						end else if (count_q != '0) begin
							remaining_q <= count_q;
							state_q     <= S_DUMP;
						end
					end
				end
				S_DUMP: begin
					if (dump_step) begin
						remaining_q <= remaining_q - CNT_W'(1);
						if (remaining_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Response payload; the head cell is read out while the chain rotates left.
	always_ff @(posedge clk) begin
		if (dump_step) begin
			rsp_entry_q  <= cell_entry[0];
			rsp_status_q <= ST_ENTRY;
			rsp_last_q   <= remaining_q == CNT_W'(1);
		end else if (req_fire) begin
			rsp_entry_q <= '0;
			rsp_last_q  <= 1'b1;
			if (req.cmd == CMD_INSERT) begin
				rsp_status_q <= full ? ST_FULL : ST_ACCEPT;
			end else begin
				rsp_status_q <= ST_EMPTY;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.out_code     = rsp_entry_q.code;
	assign rsp.out_priority = rsp_entry_q.prio;
	assign rsp.status       = rsp_status_q;
	assign rsp.last         = rsp_last_q;

endmodule
